/* sv/pulse_period_code_classifier_unit_assert.svh */
// Assertion macros for the pulse period code classifier
`ifndef PULSE_PERIOD_CODE_CLASSIFIER_UNIT_ASSERT_SVH
`define PULSE_PERIOD_CODE_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PPCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppcc: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define PPCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppcc: next-cycle check failed");

`endif

/* sv/ppcc_pkg.sv */
`timescale 1ns / 1ps
package ppcc_pkg;

    // Ring depth default
    localparam int RING_SLOTS_DEF = 10;

    // Field widths
    localparam int EDGE_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int CODE_W   = 4;
    localparam int TOL_W    = 8;
    localparam int NOM_CNT  = 16;

    // ticks / 40 = (ticks >> 3) / 5; /5 as multiply by ceil(2^34 / 5), shift 34
    localparam int        DIV_PRE_SHIFT = 3;
    localparam int        DIV_SHIFT     = 34;
    localparam logic [31:0] DIV5_MAGIC  = 32'hCCCC_CCCD;
    localparam int        PRE_W         = EDGE_W - DIV_PRE_SHIFT;
    localparam int        PROD_W        = PRE_W + 32;
    localparam int        QUOT_W        = PROD_W - DIV_SHIFT;

    // Reset value of the tolerance register
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd10;

    // Nominal periods in microseconds, code 0 is the longest
    function automatic logic [PERIOD_W-1:0] nominal_us(input logic [CODE_W-1:0] idx);
        logic [PERIOD_W-1:0] v;
        case (idx)
            4'd0:    v = 16'd1333;
            4'd1:    v = 16'd1277;
            4'd2:    v = 16'd1222;
            4'd3:    v = 16'd1166;
            4'd4:    v = 16'd1111;
            4'd5:    v = 16'd1055;
            4'd6:    v = 16'd1000;
            4'd7:    v = 16'd944;
            4'd8:    v = 16'd889;
            4'd9:    v = 16'd833;
            4'd10:   v = 16'd778;
            4'd11:   v = 16'd722;
            4'd12:   v = 16'd667;
            4'd13:   v = 16'd611;
            4'd14:   v = 16'd556;
            default: v = 16'd500;
        endcase
        return v;
    endfunction

    // One classified period
    typedef struct packed {
        logic [PERIOD_W-1:0] period_us;
        logic [CODE_W-1:0]   code;
        logic                valid;
    } t_sample;

    // One ring slot
    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   code;
    } t_slot;

    // Full result beat
    typedef struct packed {
        logic                consensus_valid;
        logic [CODE_W-1:0]   consensus_code;
        logic                sample_valid;
        logic [CODE_W-1:0]   sample_code;
        logic [PERIOD_W-1:0] period_us;
    } t_result;

endpackage

/* sv/ppcc_classify.sv */
`timescale 1ns / 1ps
module ppcc_classify (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [ppcc_pkg::QUOT_W-1:0]         i_quot,
    input  logic [ppcc_pkg::TOL_W-1:0]          i_tol,
    output ppcc_pkg::t_sample                   o_sample
);
    import ppcc_pkg::*;

    logic [PERIOD_W-1:0] w_period;
    logic [CODE_W-1:0]   w_code;
    logic                w_hit;
    t_sample             r_sample;

    // Saturate the quotient to 16 bits
    assign w_period = (|i_quot[QUOT_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}}
                                                   : i_quot[PERIOD_W-1:0];

    // Open window test on each nominal period; lowest index wins
    always_comb begin
        logic [PERIOD_W:0] lo;
        logic [PERIOD_W:0] hi;
        logic [PERIOD_W:0] p;
        w_code = '0;
        w_hit  = 1'b0;
        p      = {1'b0, w_period};
        for (int i = NOM_CNT - 1; i >= 0; i--) begin
            lo = {1'b0, nominal_us(CODE_W'(i))} - {{(PERIOD_W + 1 - TOL_W){1'b0}}, i_tol};
            hi = {1'b0, nominal_us(CODE_W'(i))} + {{(PERIOD_W + 1 - TOL_W){1'b0}}, i_tol};
            if (p > lo && p < hi) begin
                w_code = CODE_W'(i);
                w_hit  = 1'b1;
            end
        end
    end

    // Sample register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample.period_us <= w_period;
            r_sample.code      <= w_code;
            r_sample.valid     <= w_hit;
        end
    end

    assign o_sample = r_sample;

endmodule

/* sv/ppcc_ring.sv */
`timescale 1ns / 1ps
module ppcc_ring #(
    parameter int RING_SLOTS = ppcc_pkg::RING_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ppcc_pkg::t_sample    i_sample,
    output ppcc_pkg::t_result    o_result
);
    import ppcc_pkg::*;

    localparam int PTR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

    t_slot            r_slots [RING_SLOTS];
    t_slot            n_slots [RING_SLOTS];
    logic [PTR_W-1:0] r_wr_slot;
    logic             w_agree;
    t_result          r_result;

    // Ring as it stands after this sample is written
    always_comb begin
        for (int i = 0; i < RING_SLOTS; i++) begin
            if (r_wr_slot == PTR_W'(i)) begin
                n_slots[i].valid = i_sample.valid;
                n_slots[i].code  = i_sample.code;
            end else begin
                n_slots[i] = r_slots[i];
            end
        end
    end

    // Every slot valid and equal to slot zero
    always_comb begin
        w_agree = n_slots[0].valid;
        for (int i = 1; i < RING_SLOTS; i++) begin
            if (!n_slots[i].valid || n_slots[i].code != n_slots[0].code) begin
                w_agree = 1'b0;
            end
        end
    end

    // Ring slots and write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            for (int i = 0; i < RING_SLOTS; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_load) begin
            r_slots   <= n_slots;
            r_wr_slot <= (r_wr_slot == PTR_W'(RING_SLOTS - 1)) ? '0 : r_wr_slot + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result.period_us       <= i_sample.period_us;
            r_result.sample_code     <= i_sample.code;
            r_result.sample_valid    <= i_sample.valid;
            r_result.consensus_code  <= w_agree ? n_slots[0].code : '0;
            r_result.consensus_valid <= w_agree;
        end
    end

    assign o_result = r_result;

endmodule

/* sv/pulse_period_code_classifier_unit.sv */
`timescale 1ns / 1ps
// Pulse period code classifier.
// Input stream (s_axis): one 32-bit rising-edge timestamp per beat, taken from
// a free-running 40 MHz counter. The period from the previous edge (modulo
// 2^32) is turned into microseconds, saturated at 65535, matched against
// sixteen nominal periods (1333 us down to 500 us) within +/- tolerance and
// pushed into a ring of RING_SLOTS codes. Output stream (m_axis): one beat per
// input beat carrying the period, the sample code and the ring consensus.
// Configuration: i_cfg_wr_en / i_cfg_wr_data write the 8-bit tolerance; write
// it only while no beat is in flight.
// Pipeline: difference, divide-by-40 multiply, window compare, ring update
// and result register; each stage is a single register stage.
// Throughput: one beat per cycle while m_axis_tready is high.
// Reset: previous edge 0, ring slots invalid, tolerance 10, pipeline empty.
// Back-pressure: a stalled output holds its beat; empty stages upstream keep
// taking input until the pipeline is full, then s_axis_tready drops.
module pulse_period_code_classifier_unit #(
    parameter int RING_SLOTS = ppcc_pkg::RING_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [ppcc_pkg::TOL_W-1:0]   i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // [31:0] edge_time
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] period_us, [19:16] sample_code, [20] sample_valid,
    // [24:21] consensus_code, [25] consensus_valid, [31:26] zero
    output logic [31:0]                  m_axis_tdata
);
    import ppcc_pkg::*;

    logic [TOL_W-1:0]  r_tol;
    logic [EDGE_W-1:0] r_prev_edge;
    logic [EDGE_W-1:0] r_s1_ticks;
    logic [QUOT_W-1:0] r_s2_quot;
    logic [PROD_W-1:0] w_prod;
    logic              r_v1, r_v2, r_v3, r_v4;
    logic              w_adv1, w_adv2, w_adv3, w_adv4;
    t_sample           w_sample;
    t_result           w_result;

    // Stage advance: a stage moves when empty or when the next one moves
    assign w_adv4        = !r_v4 || m_axis_tready;
    assign w_adv3        = !r_v3 || w_adv4;
    assign w_adv2        = !r_v2 || w_adv3;
    assign w_adv1        = !r_v1 || w_adv2;
    assign s_axis_tready = w_adv1;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= s_axis_tvalid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    // Previous edge and wrapping difference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_edge <= '0;
        end else if (s_axis_tvalid && w_adv1) begin
            r_prev_edge <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_adv1) begin
            r_s1_ticks <= s_axis_tdata - r_prev_edge;
        end
    end

    // Divide by 40: drop three bits, then reciprocal multiply for /5
    assign w_prod = {{(PROD_W - PRE_W){1'b0}}, r_s1_ticks[EDGE_W-1:DIV_PRE_SHIFT]}
                  * {{(PROD_W - 32){1'b0}}, DIV5_MAGIC};

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_quot <= w_prod[PROD_W-1:DIV_SHIFT];
        end
    end

    // Saturate and classify
    ppcc_classify u_classify (
        .i_clk    (i_clk),
        .i_load   (w_adv3),
        .i_quot   (r_s2_quot),
        .i_tol    (r_tol),
        .o_sample (w_sample)
    );

    // Ring update, consensus and result register
    ppcc_ring #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv4 && r_v3),
        .i_sample (w_sample),
        .o_result (w_result)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {6'b0, w_result};

    // Checks
`include "pulse_period_code_classifier_unit_assert.svh"

    `PPCC_ASSERT_NOW(a_cons_needs_sample, m_axis_tvalid && m_axis_tdata[25], m_axis_tdata[20])
    `PPCC_ASSERT_NOW(a_cons_code_zero, m_axis_tvalid && !m_axis_tdata[25], m_axis_tdata[24:21] == 4'd0)
    `PPCC_ASSERT_NOW(a_sample_code_zero, m_axis_tvalid && !m_axis_tdata[20], m_axis_tdata[19:16] == 4'd0)
    `PPCC_ASSERT_NOW(a_stall_only_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

/* test/ppcc_reading_checker.sv */
`timescale 1ns / 1ps
// Watches both streams and the tolerance port, keeps its own copy of the
// period classifier and ring, and compares every output beat with the oldest
// predicted reading.
module ppcc_reading_checker #(
    parameter int RING_SLOTS = ppcc_pkg::RING_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [ppcc_pkg::TOL_W-1:0]   i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [31:0]                  m_axis_tdata,
    output int unsigned                  o_fail_count,
    output int unsigned                  o_pending
);
    import ppcc_pkg::*;

    localparam int          RESULT_W      = $bits(t_result);
    localparam int unsigned TICKS_PER_US  = 40;
    localparam int unsigned PERIOD_CEIL   = 2**PERIOD_W - 1;

    // Nominal periods, entry 0 (lowest bits) is the longest
    localparam logic [NOM_CNT-1:0][PERIOD_W-1:0] NOMINAL_US = {
        16'd500,  16'd556,  16'd611,  16'd667,  16'd722,  16'd778,  16'd833,  16'd889,
        16'd944,  16'd1000, 16'd1055, 16'd1111, 16'd1166, 16'd1222, 16'd1277, 16'd1333
    };

    // Model state
    logic [TOL_W-1:0]  tolerance;
    logic [EDGE_W-1:0] last_stamp;
    t_slot             ring [RING_SLOTS];
    int unsigned       ring_ptr;
    t_result           awaited_readings [$];
    int unsigned       fail_total;
    int unsigned       beat_no;

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] beat %0d: %s mismatch, expected %0d, got %0d",
                 $time, beat_no, what, want, got);
        fail_total++;
        o_fail_count = fail_total;
    endtask

    // Period, class and ring consensus for one timestamp; advances the model
    function automatic t_result predict_reading(input logic [EDGE_W-1:0] stamp);
        logic [EDGE_W-1:0] ticks;
        logic [EDGE_W-1:0] us_full;
        logic [PERIOD_W-1:0] us;
        logic found;
        logic agree;
        t_result r;
        ticks   = stamp - last_stamp;
        us_full = ticks / TICKS_PER_US;
        us      = (us_full > PERIOD_CEIL) ? PERIOD_W'(PERIOD_CEIL) : us_full[PERIOD_W-1:0];
        last_stamp = stamp;
        r = '0;
        r.period_us = us;

        // first open window wins
        found = 1'b0;
        for (int i = 0; i < NOM_CNT; i++) begin
            if (!found && int'(us) > int'(NOMINAL_US[i]) - int'(tolerance)
                    && int'(us) < int'(NOMINAL_US[i]) + int'(tolerance)) begin
                found = 1'b1;
                r.sample_code = CODE_W'(i);
            end
        end
        r.sample_valid = found;

        // ring write, then consensus over the updated ring
        ring[ring_ptr].valid = found;
        ring[ring_ptr].code  = r.sample_code;
        ring_ptr = (ring_ptr == RING_SLOTS - 1) ? 0 : ring_ptr + 1;
        agree = ring[0].valid;
        for (int i = 1; i < RING_SLOTS; i++) begin
            if (!ring[i].valid || ring[i].code != ring[0].code) begin
                agree = 1'b0;
            end
        end
        r.consensus_valid = agree;
        r.consensus_code  = agree ? ring[0].code : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            tolerance  = TOL_RESET;
            last_stamp = '0;
            ring_ptr   = 0;
            beat_no    = 0;
            for (int i = 0; i < RING_SLOTS; i++) begin
                ring[i] = '0;
            end
            awaited_readings.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_readings.push_back(predict_reading(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[RESULT_W-1:0]);
                if (m_axis_tdata[31:RESULT_W] !== '0) begin
                    report_mismatch("padding", 0, m_axis_tdata[31:RESULT_W]);
                end
                if (awaited_readings.size() == 0) begin
                    report_mismatch("unexpected beat", 0, m_axis_tdata);
                end else begin
                    want = awaited_readings.pop_front();
                    if (got.period_us !== want.period_us)
                        report_mismatch("period_us", want.period_us, got.period_us);
                    if (got.sample_code !== want.sample_code)
                        report_mismatch("sample_code", want.sample_code, got.sample_code);
                    if (got.sample_valid !== want.sample_valid)
                        report_mismatch("sample_valid", want.sample_valid, got.sample_valid);
                    if (got.consensus_code !== want.consensus_code)
                        report_mismatch("consensus_code", want.consensus_code,
                                        got.consensus_code);
                    if (got.consensus_valid !== want.consensus_valid)
                        report_mismatch("consensus_valid", want.consensus_valid,
                                        got.consensus_valid);
                end
                beat_no++;
            end
            if (i_cfg_wr_en) begin
                tolerance = i_cfg_wr_data;
            end
        end
        o_pending <= awaited_readings.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import ppcc_pkg::*;

    localparam time         HALF_PERIOD      = 10ns;
    localparam int          RESET_CYCLES     = 7;
    localparam int          IDLE_PCT         = 15;
    localparam int          RUN_PCT          = 75;
    localparam int          NEAR_PCT         = 88;
    localparam int          FAR_PCT          = 95;
    localparam int unsigned NEAR_US          = 1500;
    localparam int unsigned FAR_US           = 70000;
    localparam int unsigned MAX_RUN          = 16;
    localparam int unsigned PERIOD_CEIL      = 2**PERIOD_W - 1;
    localparam int unsigned RANDOM_PER_PHASE = 85;
    localparam int unsigned SQUEEZE_AFTER    = 10;
    localparam int          HOLD_CYCLES      = 100;
    localparam int          LATENCY          = 4;
    localparam int          SETTLE_CYCLES    = 2 * LATENCY;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam logic [CODE_W-1:0] FIRST_CODE = '0;
    localparam logic [CODE_W-1:0] MID_CODE   = 4'd6;
    localparam logic [CODE_W-1:0] LAST_CODE  = CODE_W'(NOM_CNT - 1);
    localparam logic [TOL_W-1:0]  TOL_FULL   = '1;
    localparam logic [TOL_W-1:0]  TOL_NONE   = '0;
    localparam logic [TOL_W-1:0]  TOL_NARROW = 8'd1;
    localparam logic [TOL_W-1:0]  TOL_WIDE   = 8'd30;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [TOL_W-1:0]   i_cfg_wr_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;
    int unsigned        fail_count;
    int unsigned        pending;

    logic [EDGE_W-1:0]  stamp_now;
    bit                 steady   = 1'b0;
    bit                 hold_req = 1'b0;
    int                 quiet_cycles = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    pulse_period_code_classifier_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ppcc_reading_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Watchdog: cycles without any beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one timestamp, with random gaps ahead of it; returns once accepted
    task automatic push_edge(input logic [EDGE_W-1:0] stamp);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Next edge a given number of whole microseconds on, plus a random fraction
    task automatic send_period(input int unsigned us_val);
        stamp_now = stamp_now + us_val * 40 + $urandom_range(39);
        push_edge(stamp_now);
    endtask

    // A run of periods around one nominal value; now and then just outside
    task automatic send_run(input int tol, output int unsigned sent);
        logic [CODE_W-1:0] code;
        int span;
        int us;
        code = CODE_W'($urandom_range(NOM_CNT - 1));
        sent = $urandom_range(1, MAX_RUN);
        span = ($urandom_range(7) == 0) ? tol + 1 : ((tol > 0) ? tol - 1 : 0);
        repeat (sent) begin
            us = int'(nominal_us(code)) + int'($urandom_range(2 * span)) - span;
            send_period(us);
        end
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] tol);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= tol;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Wait for every predicted reading to come out, then let the pipe settle
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic directed_items(input int tol);
        // first edge after reset, then a jump that saturates
        stamp_now = '0;
        push_edge(stamp_now);
        stamp_now = '1;
        push_edge(stamp_now);
        // counter wrap lands in a window
        send_period(nominal_us(MID_CODE));
        for (int c = 0; c < NOM_CNT; c++) begin
            send_period(nominal_us(CODE_W'(c)));
        end
        // window edges are open
        send_period(int'(nominal_us(FIRST_CODE)) + tol);
        send_period(int'(nominal_us(LAST_CODE)) - tol);
        send_period(int'(nominal_us(MID_CODE)) + tol - 1);
        // saturation threshold
        send_period(PERIOD_CEIL);
        send_period(PERIOD_CEIL + 1);
    endtask

    task automatic random_items(input int unsigned count, input int tol, input bit squeeze);
        int unsigned done;
        int unsigned pick;
        int unsigned sent;
        done = 0;
        while (done < count) begin
            if (squeeze && done >= SQUEEZE_AFTER) begin
                hold_req = 1'b1;
                squeeze  = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < RUN_PCT) begin
                send_run(tol, sent);
                done += sent;
            end else begin
                if (pick < NEAR_PCT) begin
                    send_period($urandom_range(NEAR_US));
                end else if (pick < FAR_PCT) begin
                    send_period($urandom_range(FAR_US));
                end else begin
                    stamp_now = $urandom;
                    push_edge(stamp_now);
                end
                done++;
            end
        end
    endtask

    task automatic run_phase(input logic [TOL_W-1:0] tol, input bit directed,
                             input bit no_idle, input bit squeeze);
        wait_drained();
        write_tolerance(tol);
        steady = no_idle;
        if (directed) begin
            directed_items(int'(tol));
        end
        random_items(RANDOM_PER_PHASE, int'(tol), squeeze);
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        stamp_now = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(TOL_RESET, 1'b1, 1'b0, 1'b0);
        run_phase(TOL_FULL, 1'b0, 1'b1, 1'b0);
        run_phase(TOL_NONE, 1'b0, 1'b0, 1'b0);
        run_phase(TOL_NARROW, 1'b0, 1'b0, 1'b0);
        run_phase(TOL_W'($urandom_range(2, 254)), 1'b0, 1'b0, 1'b1);
        run_phase(TOL_WIDE, 1'b0, 1'b0, 1'b0);
        wait_drained();

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/ppcc_pkg.sv
sv/ppcc_classify.sv
sv/ppcc_ring.sv
sv/pulse_period_code_classifier_unit.sv
test/ppcc_reading_checker.sv
test/tb_top.sv
